FILE: design/frob_pkg.sv
// ----------------------------------------------------------------------------
// frob_pkg: shared types and constants for the Frobenius norm block
// Widths of the element, square, running sum and norm, plus the item that
// carries a finished sum of squares from the accumulator to the root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frob_pkg;

  localparam int ELEM_W = 16;
  localparam int SQ_W   = 2 * ELEM_W;
  localparam int SUM_W  = 48;
  localparam int NORM_W = SUM_W / 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // A completed sum of squares for one matrix, handed on for the root.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             overflowed;
  } sum_result_t;

endpackage : frob_pkg

`default_nettype wire

FILE: design/matrix_frobenius_norm.sv
// A final element's square is registered, then its sum, then the 24-round
// root unit runs and the norm is registered. Throughput: one element per cycle
// while a matrix streams in, then the input stalls until the root is stored.
// Reset: synchronous, active high; clears the sum, the overflow flag, the
// sequencer and the output valid.
// ----------------------------------------------------------------------------
// matrix_frobenius_norm: streamed Frobenius norm in fixed point
// Accumulates squares of Q8.8 elements into a saturating Q32.16 sum and, on
// the final element of a matrix, delivers the Q16.8 floor square root.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_frobenius_norm (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [frob_pkg::ELEM_W-1:0]  element,
  input  wire logic                                final_element,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [frob_pkg::NORM_W-1:0]              norm,
  output logic                                     saturated
);
  import frob_pkg::*;

  // The sequencer: ACCUM takes elements every cycle, ROOT waits for the sum
  // to drain from the accumulator and for the root unit to finish, and HOLD
  // keeps the finished root while the output register is still occupied.
  typedef enum logic [2:0] {
    S_ACCUM = 3'b001,
    S_ROOT  = 3'b010,
    S_HOLD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  sum_result_t       handoff;
  logic              take;
  logic              root_done;
  logic [NORM_W-1:0] root;
  logic              sat_hold;
  logic              out_free;
  logic              load_out;

  // Elements are only taken in ACCUM, so every accepted item is at most one
  // matrix ahead of the root unit.
  assign in_stall = (state != S_ACCUM);
  assign take     = in_valid & ~in_stall;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = ~out_valid | ~out_stall;
  assign load_out = ((state == S_ROOT) & root_done) | (state == S_HOLD);

  frob_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .element       (element),
    .final_element (final_element),
    .handoff       (handoff)
  );

  frob_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (handoff.valid),
    .radicand (handoff.sum),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACCUM: begin
        if (take && final_element) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = out_free ? S_ACCUM : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_ACCUM;
        end
      end
      default: state_next = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // The overflow flag travels beside the sum and waits here for the root.
    if (handoff.valid) begin
      sat_hold <= handoff.overflowed;
    end
    if (load_out && out_free) begin
      norm      <= root;
      saturated <= sat_hold;
    end
  end

  // A finished sum only ever arrives while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    handoff.valid |-> state == S_ROOT)
    else $error("sum handed off outside the root phase");

  // The root unit finishes only for a matrix that is being waited on.
  assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("root finished outside the root phase");

  // HOLD is entered only because a result still occupies the output.
  assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> out_valid)
    else $error("holding a root with an empty output register");

  // A finished root is never dropped: it is either stored or held.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && root_done) |=> (out_valid && state == S_ACCUM) || state == S_HOLD)
    else $error("finished root lost");

endmodule : matrix_frobenius_norm

`default_nettype wire

FILE: design/frob_accum.sv
// ----------------------------------------------------------------------------
// frob_accum: square and saturating accumulate
// Squares each accepted element into a register, then adds it to the running
// Q32.16 sum in the next cycle, saturating with a sticky flag. On the final
// element the total is handed on and the sum is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module frob_accum (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           take,
  input  wire logic signed [frob_pkg::ELEM_W-1:0] element,
  input  wire logic                           final_element,
  output frob_pkg::sum_result_t               handoff
);
  import frob_pkg::*;

  logic signed [ELEM_W:0] elem_ext;
  logic [ELEM_W:0]        mag_full;
  logic [ELEM_W-1:0]      mag;

  logic            sq_valid;
  logic            sq_final;
  logic [SQ_W-1:0] sq;

  logic [SUM_W-1:0] square_sum;
  logic             sum_overflowed;

  logic [SUM_W:0]   sum_wide;
  logic             carry;
  logic [SUM_W-1:0] sum_next;
  logic             overflowed_next;

  // The magnitude of -32768 is 32768, which still fits in ELEM_W bits.
  assign elem_ext = {element[ELEM_W-1], element};
  assign mag_full = elem_ext[ELEM_W] ? unsigned'(-elem_ext) : unsigned'(elem_ext);
  assign mag      = mag_full[ELEM_W-1:0];

  assign sum_wide        = {1'b0, square_sum} + {{(SUM_W+1-SQ_W){1'b0}}, sq};
  assign carry           = sum_wide[SUM_W];
  assign sum_next        = carry ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign overflowed_next = sum_overflowed | carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= take;
    end
    if (take) begin
      sq_final <= final_element;
      sq       <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      sum_overflowed <= 1'b0;
      handoff.valid  <= 1'b0;
    end else begin
      handoff.valid <= sq_valid & sq_final;
      if (sq_valid) begin
        if (sq_final) begin
          square_sum     <= '0;
          sum_overflowed <= 1'b0;
        end else begin
          square_sum     <= sum_next;
          sum_overflowed <= overflowed_next;
        end
      end
    end
    if (sq_valid && sq_final) begin
      handoff.sum        <= sum_next;
      handoff.overflowed <= overflowed_next;
    end
  end

endmodule : frob_accum

`default_nettype wire

FILE: design/frob_sqrt.sv
// ----------------------------------------------------------------------------
// frob_sqrt: iterative floor square root
// One compare and subtract per cycle on the remainder, giving one root bit
// per round over 24 rounds. The root is held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module frob_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [frob_pkg::SUM_W-1:0]    radicand,
  output logic                               done,
  output logic [frob_pkg::NORM_W-1:0]        root
);
  import frob_pkg::*;

  logic             running;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] bit_mask;
  logic [SUM_W-1:0] trial;
  logic             fits;

  assign trial = acc + bit_mask;
  assign fits  = rem >= trial;
  assign root  = acc[NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running & bit_mask[0];
      if (start) begin
        running <= 1'b1;
      end else if (running && bit_mask[0]) begin
        running <= 1'b0;
      end
    end
    if (start) begin
      rem      <= radicand;
      acc      <= '0;
      bit_mask <= {2'b01, {(SUM_W-2){1'b0}}};
    end else if (running) begin
      if (fits) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bit_mask;
      end else begin
        acc <= acc >> 1;
      end
      bit_mask <= bit_mask >> 2;
    end
  end

endmodule : frob_sqrt

`default_nettype wire

FILE: tb/matrix_frobenius_norm_tb.sv
// ----------------------------------------------------------------------------
// matrix_frobenius_norm_tb: self-checking bench for the streamed Frobenius norm
// Streams signed Q8.8 matrices into the block and predicts each Q16.8 norm
// and saturation flag in the bench. Every returned item is checked against
// the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_frobenius_norm_tb;
  import frob_pkg::*;

  // Generous ceiling on the run, far above what a correct run would need even
  // if every element closed its own matrix and the receiver stalled as long as
  // it can.
  localparam int CYCLE_LIMIT   = 400000;
  // Settling time after the drain, longer than the block's latency from a final
  // element to its norm, with room to spare.
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 250;
  // Length of the long run of most negative elements in one matrix.
  localparam int LONG_LENGTH   = 48;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

  typedef struct {
    logic [NORM_W-1:0] norm;
    logic              saturated;
  } norm_result_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] element       = '0;
  logic                     final_element = 1'b0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [NORM_W-1:0]        norm;
  logic                     saturated;

  // The bench's own copy of the accumulator state.
  logic [SUM_W-1:0] running_sum   = '0;
  logic             overflow_seen = 1'b0;

  norm_result_t expected_norms[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int elements_sent = 0;

  // Receiver control. The test sequence raises hold_ticket to ask for one
  // long hold-off, and the stall process alone counts it down.
  int   hold_ticket = 0;
  int   hold_served = 0;
  int   hold_left   = 0;
  int   burst_left  = 0;
  logic no_idle     = 1'b0;

  matrix_frobenius_norm dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element       (element),
    .final_element (final_element),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .norm          (norm),
    .saturated     (saturated)
  );

  always #10 clk = ~clk;

  // Floor square root by building the root one bit at a time from the top,
  // keeping each bit whose square still fits under the value.
  function automatic logic [NORM_W-1:0] floor_root(input logic [SUM_W-1:0] value);
    logic [NORM_W-1:0] root;
    logic [SUM_W-1:0]  trial;
    root = '0;
    for (int b = NORM_W - 1; b >= 0; b--) begin
      trial = SUM_W'(root | (NORM_W'(1) << b));
      if (trial * trial <= value) begin
        root = trial[NORM_W-1:0];
      end
    end
    return root;
  endfunction

  // Folds one accepted element into the predicted sum. A final element
  // closes the matrix and queues the norm that the block must return.
  task automatic accumulate_square(input logic signed [ELEM_W-1:0] e, input logic fin);
    logic [ELEM_W:0]  magnitude;
    logic [SUM_W-1:0] square;
    norm_result_t     result;
    // The magnitude needs one extra bit so that -32768 comes out as +32768.
    magnitude = e[ELEM_W-1] ? -{1'b1, e} : {1'b0, e};
    square    = SUM_W'(magnitude) * SUM_W'(magnitude);
    if (square > SUM_MAX - running_sum) begin
      running_sum   = SUM_MAX;
      overflow_seen = 1'b1;
    end else begin
      running_sum = running_sum + square;
    end
    if (fin) begin
      result.norm      = floor_root(running_sum);
      result.saturated = overflow_seen;
      expected_norms.push_back(result);
      running_sum   = '0;
      overflow_seen = 1'b0;
    end
  endtask

  // Offers one element and waits for the handshake. The payload is driven
  // just after a rising edge and holds until the block takes it; acceptance
  // is judged on the values present at the edge itself. When idling is
  // allowed, a short random gap may follow.
  task automatic send_element(input logic signed [ELEM_W-1:0] e, input logic fin);
    int gap;
    in_valid      <= 1'b1;
    element       <= e;
    final_element <= fin;
    do begin
      @(posedge clk);
    end while (in_stall);
    accumulate_square(e, fin);
    elements_sent++;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted norm has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_norms.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Draws an element from a spread that favours full-range values but also
  // visits small values, both extremes and large magnitudes.
  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return ELEM_W'($urandom);
      6:                return ELEM_W'($signed($urandom_range(0, 32)) - 16);
      7:                return $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
      default:          return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
    endcase
  endfunction

  // Sends one matrix of the given length with random content.
  task automatic send_random_matrix(input int length);
    for (int i = 0; i < length; i++) begin
      send_element(random_element(), i == length - 1);
    end
  endtask

  // Extremes of the element field, single-element matrices and a few small
  // matrices whose norms are easy to read by eye.
  task automatic test_directed_extremes();
    send_element(16'sh0000, 1'b1);
    send_element(16'sh0001, 1'b1);
    send_element(-16'sh0001, 1'b1);
    send_element(ELEM_MAX, 1'b1);
    send_element(ELEM_MIN, 1'b1);
    send_element(16'sh0100, 1'b1);
    send_element(-16'sh0180, 1'b1);
    // Three and four give a norm of exactly five.
    send_element(16'sh0300, 1'b0);
    send_element(-16'sh0400, 1'b1);
    // A 2x2 matrix of both extremes, in row-major order.
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MAX, 1'b1);
    // Zeros ahead of a non-zero final element.
    send_element(16'sh0000, 1'b0);
    send_element(16'sh0000, 1'b0);
    send_element(16'sh0002, 1'b1);
  endtask

  // One long matrix of the most negative element, whose square is the
  // largest of all. Taking the sum to its ceiling would need 2^18 such
  // elements, far more than the whole run sends, so the sum stays below it
  // here. The next matrix must start from a clear sum.
  task automatic test_long_extreme_matrix();
    no_idle <= 1'b1;
    repeat (LONG_LENGTH) send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MAX, 1'b0);
    send_element(16'sh1234, 1'b0);
    send_element(16'sh0005, 1'b1);
    no_idle <= 1'b0;
    send_element(16'sh0200, 1'b1);
    send_random_matrix(3);
  endtask

  // The receiver holds off for a long stretch while short matrices keep
  // coming, so the block fills up and has to stall its input.
  task automatic test_output_backpressure();
    hold_ticket <= hold_ticket + 1;
    repeat (30) send_random_matrix($urandom_range(1, 3));
  endtask

  // The sender goes quiet until every norm has come back, then resumes.
  task automatic test_sender_pause();
    repeat (4) send_random_matrix($urandom_range(1, 4));
    wait_for_drain();
    repeat (4) send_random_matrix($urandom_range(1, 4));
  endtask

  // The bulk of the run: matrices of mostly small random sizes, with an
  // occasional longer one.
  task automatic test_random_matrices(input int target);
    int stop_at;
    stop_at = elements_sent + target;
    while (elements_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        send_random_matrix($urandom_range(20, 60));
      end else begin
        send_random_matrix($urandom_range(1, 12));
      end
    end
  endtask

  // The last stretch runs with no idling on either side, so the block
  // streams at its full rate.
  task automatic test_full_rate_stream(input int target);
    no_idle <= 1'b1;
    test_random_matrices(target);
  endtask

  // Receiver side: honours a requested long hold-off first, then random
  // stall bursts, unless idling is switched off.
  always @(posedge clk) begin
    if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall  <= 1'b0;
      burst_left <= 0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checks every item taken from the output against the oldest prediction.
  // Only the first ten failures are described; the rest are counted.
  always @(posedge clk) begin
    norm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected norm item: norm=%h saturated=%b", norm, saturated);
        end
      end else begin
        want = expected_norms.pop_front();
        if (norm !== want.norm || saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("norm mismatch: expected norm=%h saturated=%b, got norm=%h saturated=%b",
                     want.norm, want.saturated, norm, saturated);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("** matrix_frobenius_norm: FAILED **");
      $finish;
    end
  end

  // Test sequence. Reset is held from time zero and released at an edge,
  // after which each test runs in turn.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_long_extreme_matrix();
    test_output_backpressure();
    test_sender_pause();
    test_random_matrices(820);
    test_full_rate_stream(160);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_norms.size() == 0) begin
      $display("** matrix_frobenius_norm: PASSED **");
    end else begin
      $display("** matrix_frobenius_norm: FAILED **");
    end
    $finish;
  end

endmodule : matrix_frobenius_norm_tb

`default_nettype wire
